// ----- rtl/nsr_pkg.sv -----
// Shared constants, codes and control types for the n-step return ring store.
package nsr_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int MAX_WINDOW  = 8;

    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int ACTION_W   = 16;
    localparam int RET_W      = 32;
    localparam int IDX_W      = 10;
    localparam int SLOT_W     = 10;
    localparam int OCC_W      = 11;
    localparam int WS_W       = 4;
    localparam int DISC_W     = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam int S_PAY_W    = ACTION_W + RET_W + IDX_W;
    localparam int S_TDATA_W  = ((S_PAY_W + 7) / 8) * 8;
    localparam int M_PAY_W    = SLOT_W + ACTION_W + RET_W + 1 + OCC_W;
    localparam int M_TDATA_W  = ((M_PAY_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_PAY_W;

    localparam logic [WS_W-1:0]   WS_RESET   = 4'd3;
    localparam logic [DISC_W-1:0] DISC_RESET = 17'd64880;
    localparam logic [DISC_W-1:0] DISC_ONE   = 17'd65536;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORED = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_STEPS = 1'b0,
        CFG_DISCOUNT     = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_GO,
        ST_WALK,
        ST_INSERT,
        ST_DECIDE,
        ST_WIN_RD,
        ST_WIN_OUT,
        ST_RD_MOD,
        ST_RD_ISSUE,
        ST_RD_OUT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [RET_W-1:0]    ret;
    } win_entry_t;

    typedef struct packed {
        logic                walk_start;
        logic                insert;
        logic                rd_req;
        logic                empty;
        logic [ACTION_W-1:0] action;
        logic [RET_W-1:0]    reward;
        logic [DISC_W-1:0]   discount;
    } win_ctrl_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [RET_W-1:0]    ret;
        logic                done;
    } st_entry_t;

    typedef struct packed {
        logic      we;
        logic      re;
        logic      clear;
        st_entry_t wdata;
    } st_ctrl_t;

endpackage

// ----- rtl/nsr_window.sv -----
// Window memory with the discounted-return accumulate walk, eviction and insert.
module nsr_window #(
    parameter int MAX_WINDOW = nsr_pkg::MAX_WINDOW,
    localparam int WA = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int FW = $clog2(MAX_WINDOW + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nsr_pkg::win_ctrl_t  ctrl,
    input  logic [FW-1:0]       ws_eff,
    input  logic [FW-1:0]       rd_offset,
    output logic [FW-1:0]       fill,
    output logic                busy,
    output nsr_pkg::win_entry_t rdata
);
    localparam int SW = FW + 1;
    localparam logic [SW-1:0] MW_S   = SW'(MAX_WINDOW);
    localparam logic [WA-1:0] LAST_A = WA'(MAX_WINDOW - 1);

    nsr_pkg::win_entry_t mem [MAX_WINDOW];
    nsr_pkg::win_entry_t rdata_reg;
    nsr_pkg::win_entry_t wdata;

    logic [WA-1:0]      head_reg;
    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      walk_cnt_reg;
    logic [WA-1:0]      walk_addr_reg;
    logic [WA-1:0]      wb_addr_reg;
    logic               wb_valid_reg;
    logic [16:0]        p_reg;
    logic [16:0]        p_next;
    logic [33:0]        pw_full;
    logic signed [48:0] prod_reg;
    logic signed [48:0] prod_next;
    logic signed [49:0] rnd;
    logic signed [33:0] term;
    logic signed [34:0] sum;
    logic [31:0]        sat;
    logic               issue;
    logic               mem_re;
    logic               mem_we;
    logic [WA-1:0]      raddr;
    logic [WA-1:0]      waddr;
    logic [WA-1:0]      tail;
    logic [WA-1:0]      start_addr;
    logic [WA-1:0]      rd_addr;
    logic [WA-1:0]      new_head;
    logic [FW-1:0]      new_fill;

    function automatic logic [WA-1:0] wrap(input logic [SW-1:0] s);
        return (s >= MW_S) ? WA'(s - MW_S) : WA'(s);
    endfunction

    assign issue = (walk_cnt_reg != '0);
    assign busy  = issue || wb_valid_reg;
    assign fill  = fill_reg;
    assign rdata = rdata_reg;

    // newest entry first; oldest entry sits at head
    assign tail       = wrap(SW'(head_reg) + SW'(fill_reg));
    assign start_addr = wrap(SW'(head_reg) + SW'(fill_reg) - SW'(1));
    assign rd_addr    = wrap(SW'(head_reg) + SW'(rd_offset));

    always_comb begin
        if (fill_reg >= ws_eff) begin
            new_head = wrap(SW'(head_reg) + SW'(fill_reg) - SW'(ws_eff) + SW'(1));
            new_fill = ws_eff - FW'(1);
        end else begin
            new_head = head_reg;
            new_fill = fill_reg;
        end
    end

    assign prod_next = $signed({1'b0, p_reg}) * $signed(ctrl.reward);
    assign pw_full   = 34'(p_reg) * 34'(ctrl.discount) + 34'd32768;
    assign p_next    = pw_full[32:16];

    assign rnd  = 50'(prod_reg) + 50'sd32768;
    assign term = $signed(rnd[49:16]);
    assign sum  = 35'(term) + 35'($signed(rdata_reg.ret));

    always_comb begin
        if (!sum[34] && (sum[33:31] != 3'b000)) begin
            sat = 32'h7FFF_FFFF;
        end else if (sum[34] && (sum[33:31] != 3'b111)) begin
            sat = 32'h8000_0000;
        end else begin
            sat = sum[31:0];
        end
    end

    always_comb begin
        mem_re = issue || ctrl.rd_req;
        raddr  = issue ? walk_addr_reg : rd_addr;
        mem_we = wb_valid_reg || ctrl.insert;
        waddr  = wb_valid_reg ? wb_addr_reg : tail;
        if (wb_valid_reg) begin
            wdata.action = rdata_reg.action;
            wdata.ret    = sat;
        end else begin
            wdata.action = ctrl.action;
            wdata.ret    = ctrl.reward;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            fill_reg     <= '0;
            walk_cnt_reg <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            wb_valid_reg <= issue;
            if (ctrl.walk_start) begin
                walk_cnt_reg <= fill_reg;
            end else if (issue) begin
                walk_cnt_reg <= walk_cnt_reg - FW'(1);
            end
            if (ctrl.empty) begin
                fill_reg <= '0;
            end else if (ctrl.insert) begin
                head_reg <= new_head;
                fill_reg <= new_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.walk_start) begin
            walk_addr_reg <= start_addr;
            p_reg         <= ctrl.discount;
        end else if (issue) begin
            walk_addr_reg <= (walk_addr_reg == '0) ? LAST_A : walk_addr_reg - WA'(1);
            p_reg         <= p_next;
            prod_reg      <= prod_next;
            wb_addr_reg   <= walk_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ----- rtl/nsr_store.sv -----
// Circular store memory with write pointer, wrap flag and logical-to-physical read.
module nsr_store #(
    parameter int STORE_DEPTH = nsr_pkg::STORE_DEPTH,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  nsr_pkg::st_ctrl_t  ctrl,
    input  logic [AW-1:0]      rd_idx,
    output logic [AW-1:0]      wr_ptr,
    output logic [AW:0]        occ,
    output logic [AW:0]        occ_after_wr,
    output logic [AW-1:0]      rd_slot,
    output nsr_pkg::st_entry_t rdata
);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_P  = AW'(STORE_DEPTH - 1);

    nsr_pkg::st_entry_t mem [STORE_DEPTH];
    nsr_pkg::st_entry_t mem_q;

    logic [AW-1:0] ptr_reg;
    logic          wrapped_reg;
    logic          blank_reg;
    logic [AW-1:0] rd_slot_reg;
    logic [AW:0]   sum;
    logic [AW-1:0] phys;
    logic          blank;

    assign wr_ptr       = ptr_reg;
    assign occ          = wrapped_reg ? DEPTH_S : (AW + 1)'(ptr_reg);
    assign occ_after_wr = (wrapped_reg || (ptr_reg == LAST_P)) ? DEPTH_S
                                                               : (AW + 1)'(ptr_reg) + 1'b1;

    // slots at or past the pointer have not been written since reset or clear
    assign sum   = (AW + 1)'(rd_idx) + (AW + 1)'(ptr_reg);
    assign phys  = !wrapped_reg ? rd_idx
                 : (sum >= DEPTH_S) ? AW'(sum - DEPTH_S) : AW'(sum);
    assign blank = !wrapped_reg && (rd_idx >= ptr_reg);

    assign rd_slot = rd_slot_reg;
    assign rdata   = blank_reg ? '0 : mem_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
        end else if (ctrl.clear) begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
        end else if (ctrl.we) begin
            if (ptr_reg == LAST_P) begin
                ptr_reg     <= '0;
                wrapped_reg <= 1'b1;
            end else begin
                ptr_reg <= ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            mem[ptr_reg] <= ctrl.wdata;
        end
        if (ctrl.re) begin
            mem_q       <= mem[phys];
            blank_reg   <= blank;
            rd_slot_reg <= phys;
        end
    end

endmodule

// ----- rtl/n_step_return_ring_store.sv -----
// Top level: command sequencer, config registers and output register of the return store.
// Append: with an empty window the entry is inserted at once, else the accumulate walk
// (one walk step per held entry on the shared multiplier) runs first; each stored datum is
// a window read, then an output load. Read: reciprocal index reduction, then the store read.
// A new transfer is taken while the last result waits in the output register.
// Reset and clear need no sweep: store reads past the write pointer return zero.
module n_step_return_ring_store #(
    parameter int STORE_DEPTH = nsr_pkg::STORE_DEPTH,
    parameter int MAX_WINDOW  = nsr_pkg::MAX_WINDOW
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [nsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action_in[15:0], reward_in[47:16], read_index[57:48], zero pad
    input  logic [nsr_pkg::S_TDATA_W-1:0]    s_tdata,
    // command
    input  logic [nsr_pkg::CMD_W-1:0]        s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot[9:0], action_out[25:10], return_out[57:26], done_out[58], occupancy[69:59], zero pad
    output logic [nsr_pkg::M_TDATA_W-1:0]    m_tdata,
    // kind
    output logic [nsr_pkg::KIND_W-1:0]       m_tuser,
    output logic                             m_tlast
);
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int FW    = $clog2(MAX_WINDOW + 1);
    localparam int WSC_W = (nsr_pkg::WS_W > FW) ? nsr_pkg::WS_W : FW;
    localparam int MOD_W = nsr_pkg::IDX_W + AW + 1;
    localparam int RS    = nsr_pkg::IDX_W + AW;
    localparam int RW    = 2 * nsr_pkg::IDX_W + 2;
    localparam logic [RW-1:0]    RECIP   = RW'((longint'(1) << RS) / STORE_DEPTH + 1);
    localparam logic [MOD_W-1:0] DEPTH_M = MOD_W'(STORE_DEPTH);

    nsr_pkg::state_t   state_reg, state_next;
    nsr_pkg::win_ctrl_t win_ctrl;
    nsr_pkg::st_ctrl_t  st_ctrl;
    nsr_pkg::win_entry_t win_rdata;
    nsr_pkg::st_entry_t  st_rdata;

    logic [nsr_pkg::WS_W-1:0]     ws_reg;
    logic [nsr_pkg::DISC_W-1:0]   disc_reg;
    logic [WSC_W-1:0]             ws_wide;
    logic [FW-1:0]                ws_eff;
    logic [nsr_pkg::DISC_W-1:0]   g_eff;

    logic [nsr_pkg::ACTION_W-1:0] act_reg;
    logic [nsr_pkg::RET_W-1:0]    rew_reg;
    logic                         done_reg;
    logic [nsr_pkg::IDX_W-1:0]    rem_reg;
    logic [nsr_pkg::IDX_W-1:0]    quot_reg;
    logic [FW-1:0]                k_reg;
    logic [FW-1:0]                last_k;

    logic [RW-1:0]                quot_full;

    logic [FW-1:0]                win_fill;
    logic                         win_busy;
    logic [AW-1:0]                st_wr_ptr;
    logic [AW:0]                  st_occ;
    logic [AW:0]                  st_occ_after;
    logic [AW-1:0]                st_rd_slot;

    logic                         s_accept;
    logic                         out_free;
    logic                         load_out;
    logic                         m_valid_reg;

    nsr_pkg::kind_t               kind_next, kind_reg;
    logic [nsr_pkg::SLOT_W-1:0]   slot_next, slot_reg;
    logic [nsr_pkg::ACTION_W-1:0] act_out_next, act_out_reg;
    logic [nsr_pkg::RET_W-1:0]    ret_next, ret_reg;
    logic                         done_next, done_out_reg;
    logic [nsr_pkg::OCC_W-1:0]    occ_next, occ_reg;
    logic                         last_next, last_reg;

    nsr_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .ws_eff    (ws_eff),
        .rd_offset (k_reg),
        .fill      (win_fill),
        .busy      (win_busy),
        .rdata     (win_rdata)
    );

    nsr_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (st_ctrl),
        .rd_idx       (AW'(rem_reg)),
        .wr_ptr       (st_wr_ptr),
        .occ          (st_occ),
        .occ_after_wr (st_occ_after),
        .rd_slot      (st_rd_slot),
        .rdata        (st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg   <= nsr_pkg::WS_RESET;
            disc_reg <= nsr_pkg::DISC_RESET;
        end else if (cfg_we) begin
            unique case (nsr_pkg::cfg_idx_t'(cfg_index))
                nsr_pkg::CFG_WINDOW_STEPS: ws_reg   <= cfg_wdata[nsr_pkg::WS_W-1:0];
                nsr_pkg::CFG_DISCOUNT:     disc_reg <= cfg_wdata[nsr_pkg::DISC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ws_wide = WSC_W'(ws_reg);
        if (ws_wide == '0) begin
            ws_eff = FW'(1);
        end else if (ws_wide > WSC_W'(MAX_WINDOW)) begin
            ws_eff = FW'(MAX_WINDOW);
        end else begin
            ws_eff = FW'(ws_wide);
        end
        g_eff = (disc_reg > nsr_pkg::DISC_ONE) ? nsr_pkg::DISC_ONE : disc_reg;
    end

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign last_k    = done_reg ? win_fill - FW'(1) : '0;
    // quotient of the read index by the store depth, by reciprocal multiply
    assign quot_full = RW'(s_tdata[57:48]) * RECIP;

    always_comb begin
        state_next        = state_reg;
        s_tready          = 1'b0;
        load_out          = 1'b0;
        win_ctrl          = '0;
        win_ctrl.action   = act_reg;
        win_ctrl.reward   = rew_reg;
        win_ctrl.discount = g_eff;
        st_ctrl           = '0;
        st_ctrl.wdata     = '{action: win_rdata.action, ret: win_rdata.ret, done: done_reg};
        kind_next         = nsr_pkg::KIND_STORED;
        slot_next         = nsr_pkg::SLOT_W'(st_wr_ptr);
        act_out_next      = win_rdata.action;
        ret_next          = win_rdata.ret;
        done_next         = done_reg;
        occ_next          = nsr_pkg::OCC_W'(st_occ_after);
        last_next         = (k_reg == last_k);
        unique case (state_reg)
            nsr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (nsr_pkg::cmd_t'(s_tuser))
                        nsr_pkg::CMD_APPEND:
                            state_next = (win_fill != '0) ? nsr_pkg::ST_WALK_GO
                                                          : nsr_pkg::ST_INSERT;
                        nsr_pkg::CMD_READ:  state_next = nsr_pkg::ST_RD_MOD;
                        nsr_pkg::CMD_CLEAR: state_next = nsr_pkg::ST_CLEAR;
                        default:            state_next = nsr_pkg::ST_IDLE;
                    endcase
                end
            end
            nsr_pkg::ST_WALK_GO: begin
                win_ctrl.walk_start = 1'b1;
                state_next          = nsr_pkg::ST_WALK;
            end
            nsr_pkg::ST_WALK: begin
                if (!win_busy) begin
                    state_next = nsr_pkg::ST_INSERT;
                end
            end
            nsr_pkg::ST_INSERT: begin
                win_ctrl.insert = 1'b1;
                state_next      = nsr_pkg::ST_DECIDE;
            end
            nsr_pkg::ST_DECIDE: begin
                state_next = (done_reg || (win_fill == ws_eff)) ? nsr_pkg::ST_WIN_RD
                                                                : nsr_pkg::ST_IDLE;
            end
            nsr_pkg::ST_WIN_RD: begin
                win_ctrl.rd_req = 1'b1;
                state_next      = nsr_pkg::ST_WIN_OUT;
            end
            nsr_pkg::ST_WIN_OUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    st_ctrl.we = 1'b1;
                    if (k_reg == last_k) begin
                        win_ctrl.empty = done_reg;
                        state_next     = nsr_pkg::ST_IDLE;
                    end else begin
                        state_next = nsr_pkg::ST_WIN_RD;
                    end
                end
            end
            nsr_pkg::ST_RD_MOD: begin
                state_next = nsr_pkg::ST_RD_ISSUE;
            end
            nsr_pkg::ST_RD_ISSUE: begin
                st_ctrl.re = 1'b1;
                state_next = nsr_pkg::ST_RD_OUT;
            end
            nsr_pkg::ST_RD_OUT: begin
                kind_next    = nsr_pkg::KIND_READ;
                slot_next    = nsr_pkg::SLOT_W'(st_rd_slot);
                act_out_next = st_rdata.action;
                ret_next     = st_rdata.ret;
                done_next    = st_rdata.done;
                occ_next     = nsr_pkg::OCC_W'(st_occ);
                last_next    = 1'b1;
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = nsr_pkg::ST_IDLE;
                end
            end
            nsr_pkg::ST_CLEAR: begin
                kind_next    = nsr_pkg::KIND_CLEAR;
                slot_next    = '0;
                act_out_next = '0;
                ret_next     = '0;
                done_next    = 1'b0;
                occ_next     = '0;
                last_next    = 1'b1;
                if (out_free) begin
                    load_out       = 1'b1;
                    win_ctrl.empty = 1'b1;
                    st_ctrl.clear  = 1'b1;
                    state_next     = nsr_pkg::ST_IDLE;
                end
            end
            default: state_next = nsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nsr_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg  <= s_tdata[15:0];
            rew_reg  <= s_tdata[47:16];
            done_reg <= s_tlast;
            rem_reg  <= s_tdata[57:48];
            quot_reg <= nsr_pkg::IDX_W'(quot_full >> RS);
        end else if (state_reg == nsr_pkg::ST_RD_MOD) begin
            // read index modulo the store depth
            rem_reg <= rem_reg - nsr_pkg::IDX_W'(MOD_W'(quot_reg) * DEPTH_M);
        end
        if (state_reg == nsr_pkg::ST_DECIDE) begin
            k_reg <= '0;
        end else if ((state_reg == nsr_pkg::ST_WIN_OUT) && load_out) begin
            k_reg <= k_reg + FW'(1);
        end
        if (load_out) begin
            kind_reg     <= kind_next;
            slot_reg     <= slot_next;
            act_out_reg  <= act_out_next;
            ret_reg      <= ret_next;
            done_out_reg <= done_next;
            occ_reg      <= occ_next;
            last_reg     <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{nsr_pkg::M_PAD_W{1'b0}}, occ_reg, done_out_reg, ret_reg,
                       act_out_reg, slot_reg};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == nsr_pkg::CMD_APPEND ||
         s_tuser == nsr_pkg::CMD_READ || s_tuser == nsr_pkg::CMD_CLEAR)) |=> !s_tready)
        else $error("transfer taken while a command is in progress");

    a_insert_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        win_ctrl.insert |-> !win_busy)
        else $error("window insert overlaps the accumulate walk");

    a_fill_after_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        win_ctrl.insert |=> (win_fill != '0))
        else $error("window empty after insert");

    a_store_write_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        st_ctrl.we |-> (load_out && out_free))
        else $error("store written without a result transfer");
`endif

endmodule
